/* hdl/rlbd_pkg.sv */
`timescale 1ns / 1ps

package rlbd_pkg;

   // Field and counter widths.
   localparam int SAMPLE_W    = 10;
   localparam int SUM_W       = 13;
   localparam int FILL_W      = 3;
   localparam int COUNT_W     = 8;
   localparam int BUTTON_W    = 3;
   localparam int SLOT_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // Vote slots: slot zero counts "no button", the others follow the window order.
   localparam int NUM_SLOTS = 5;
   localparam logic [SLOT_W-1:0] SLOT_NONE     = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_FIRST    = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_SECOND   = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_THIRD    = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_FOURTH   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_NO_CLASS = 3'd5;

   // Queue between the accumulator and the decision logic.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOTE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AVERAGES   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NULL_LEVEL     = 2'd3;

   // Configuration reset values.
   localparam logic                  RESET_LADDER_MODE    = 1'b0;
   localparam logic [COUNT_W-1:0]    RESET_VOTE_THRESHOLD = 8'd10;
   localparam logic [COUNT_W-1:0]    RESET_MAX_AVERAGES   = 8'd200;
   localparam logic [SAMPLE_W-1:0]   RESET_NULL_LEVEL     = 10'd5;

   // Button codes on the response channel.
   localparam logic [BUTTON_W-1:0] BTN_NONE     = 3'd0;
   localparam logic [BUTTON_W-1:0] BTN_NORTH    = 3'd1;
   localparam logic [BUTTON_W-1:0] BTN_EAST     = 3'd2;
   localparam logic [BUTTON_W-1:0] BTN_WEST     = 3'd3;
   localparam logic [BUTTON_W-1:0] BTN_SOUTH    = 3'd4;
   localparam logic [BUTTON_W-1:0] BTN_AUX_WEST = 3'd5;
   localparam logic [BUTTON_W-1:0] BTN_AUX_EAST = 3'd6;
   localparam logic [BUTTON_W-1:0] BTN_TIMEOUT  = 3'd7;

   // Window bounds, both exclusive.
   localparam logic [SAMPLE_W-1:0] NORTH_LO    = 10'd830;
   localparam logic [SAMPLE_W-1:0] NORTH_HI    = 10'd870;
   localparam logic [SAMPLE_W-1:0] EAST_LO     = 10'd703;
   localparam logic [SAMPLE_W-1:0] EAST_HI     = 10'd743;
   localparam logic [SAMPLE_W-1:0] WEST_LO     = 10'd495;
   localparam logic [SAMPLE_W-1:0] WEST_HI     = 10'd535;
   localparam logic [SAMPLE_W-1:0] SOUTH_LO    = 10'd312;
   localparam logic [SAMPLE_W-1:0] SOUTH_HI    = 10'd352;
   localparam logic [SAMPLE_W-1:0] AUX_WEST_LO = 10'd687;
   localparam logic [SAMPLE_W-1:0] AUX_WEST_HI = 10'd727;
   localparam logic [SAMPLE_W-1:0] AUX_EAST_LO = 10'd297;
   localparam logic [SAMPLE_W-1:0] AUX_EAST_HI = 10'd337;

   // One finished group of samples.
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
   } group_type;

   // Configuration registers as seen by the decision logic.
   typedef struct packed {
      logic                mode;
      logic [COUNT_W-1:0]  threshold;
      logic [COUNT_W-1:0]  max_avg;
      logic [SAMPLE_W-1:0] null_level;
   } cfg_type;

   // Queue status toward the accumulator and the decision logic.
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

/* hdl/rlbd_front.sv */
`timescale 1ns / 1ps

module rlbd_front import rlbd_pkg::*; #(
   parameter int GROUP_SIZE = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_scan_start,
   input  queue_status_type    q_status,
   output logic                q_push,
   output group_type           q_item
);

   // The fill count wraps at eight, so a group of eight ends on a count of zero.
   localparam logic [FILL_W-1:0] FillEnd = FILL_W'(GROUP_SIZE % 8);

   logic                active_ff, active_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                start_ff, start_in;
   logic                take;
   logic [SUM_W-1:0]    base_sum, acc_sum;
   logic [FILL_W-1:0]   base_fill, acc_fill;
   logic                base_start;

   // A request is taken whenever the queue has room for a finished group.
   assign req_ready = !q_status.full;
   assign take      = req_valid && !q_status.full;

   // A scan start throws away the partial group and opens a new one.
   assign base_sum   = req_scan_start ? '0 : sum_ff;
   assign base_fill  = req_scan_start ? '0 : fill_ff;
   assign base_start = req_scan_start ? 1'b1 : start_ff;
   assign acc_sum    = base_sum + SUM_W'(req_sample);
   assign acc_fill   = base_fill + 1'b1;

   // Accumulate samples and hand each full group to the queue.
   always_comb begin
      active_in = active_ff;
      sum_in    = sum_ff;
      fill_in   = fill_ff;
      start_in  = start_ff;
      q_push    = 1'b0;
      q_item    = '0;
      if (take && (req_scan_start || active_ff)) begin
         active_in = 1'b1;
         if (acc_fill == FillEnd) begin
            q_push       = 1'b1;
            q_item.start = base_start;
            q_item.sum   = acc_sum;
            sum_in       = '0;
            fill_in      = '0;
            start_in     = 1'b0;
         end else begin
            sum_in   = acc_sum;
            fill_in  = acc_fill;
            start_in = base_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sum_ff    <= '0;
         fill_ff   <= '0;
         start_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         sum_ff    <= sum_in;
         fill_ff   <= fill_in;
         start_ff  <= start_in;
      end
   end

endmodule

/* hdl/rlbd_queue.sv */
`timescale 1ns / 1ps

module rlbd_queue import rlbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  group_type        push_item,
   input  logic             pop,
   output group_type        head_item,
   output queue_status_type status
);

   group_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/rlbd_back.sv */
`timescale 1ns / 1ps

module rlbd_back import rlbd_pkg::*; #(
   parameter int GROUP_SIZE = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  queue_status_type    q_status,
   input  group_type           q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BUTTON_W-1:0] rsp_button
);

   // The average is taken as sum times a scaled reciprocal, which is low by at
   // most one for every sum below 2**SUM_W, then corrected from the remainder.
   localparam int RecipShift = 16;
   localparam int RecipW     = RecipShift + 1;
   localparam int ProdW      = SUM_W + RecipW;
   localparam logic [RecipW-1:0] Recip      = RecipW'((2 ** RecipShift) / GROUP_SIZE);
   localparam logic [SUM_W-1:0]  GroupConst = SUM_W'(GROUP_SIZE);

   // Sort an average into a vote slot.
   function automatic logic [SLOT_W-1:0] classify(input logic [SAMPLE_W-1:0] avg,
                                                 input cfg_type c);
      logic [SLOT_W-1:0] slot;
      begin
         slot = SLOT_NO_CLASS;
         if (c.mode == 1'b0) begin
            priority if (avg > NORTH_LO && avg < NORTH_HI) begin
               slot = SLOT_FIRST;
            end else if (avg > EAST_LO && avg < EAST_HI) begin
               slot = SLOT_SECOND;
            end else if (avg > WEST_LO && avg < WEST_HI) begin
               slot = SLOT_THIRD;
            end else if (avg > SOUTH_LO && avg < SOUTH_HI) begin
               slot = SLOT_FOURTH;
            end else if (avg < c.null_level) begin
               slot = SLOT_NONE;
            end else begin
               slot = SLOT_NO_CLASS;
            end
         end else begin
            priority if (avg > AUX_WEST_LO && avg < AUX_WEST_HI) begin
               slot = SLOT_FIRST;
            end else if (avg > AUX_EAST_LO && avg < AUX_EAST_HI) begin
               slot = SLOT_SECOND;
            end else if (avg < c.null_level) begin
               slot = SLOT_NONE;
            end else begin
               slot = SLOT_NO_CLASS;
            end
         end
         return slot;
      end
   endfunction

   // Map a slot to its button code under the current mode.
   function automatic logic [BUTTON_W-1:0] slot_code(input logic [SLOT_W-1:0] slot,
                                                    input logic mode);
      logic [BUTTON_W-1:0] code;
      begin
         code = BTN_NONE;
         unique case (slot)
            SLOT_FIRST:  code = mode ? BTN_AUX_WEST : BTN_NORTH;
            SLOT_SECOND: code = mode ? BTN_AUX_EAST : BTN_EAST;
            SLOT_THIRD:  code = BTN_WEST;
            SLOT_FOURTH: code = BTN_SOUTH;
            default:     code = BTN_NONE;
         endcase
         return code;
      end
   endfunction

   // Divide stage.
   logic                 a_valid_ff, a_valid_in;
   group_type            a_item_ff;
   logic [SAMPLE_W-1:0]  a_quot_ff;
   logic [ProdW-1:0]     prod;
   logic [SAMPLE_W-1:0]  quot_est;

   // Decision stage.
   logic                 b_fire, a_free;
   logic [SUM_W-1:0]     prod_back, remainder;
   logic [SAMPLE_W-1:0]  avg;
   logic [SLOT_W-1:0]    slot;
   logic                 scan_live;
   logic [COUNT_W-1:0]   seen_base, seen_next;
   logic [COUNT_W-1:0]   votes_base [NUM_SLOTS];
   logic [COUNT_W-1:0]   vote_cur, vote_next;
   logic                 hit, timeout;

   // Scan state and output register.
   logic                 active_ff, active_in;
   logic [COUNT_W-1:0]   seen_ff, seen_in;
   logic [COUNT_W-1:0]   votes_ff [NUM_SLOTS];
   logic [COUNT_W-1:0]   votes_in [NUM_SLOTS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BUTTON_W-1:0]  rsp_button_ff, rsp_button_in;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_button = rsp_button_ff;

   // Stage handshakes: the decision stage moves when the output register is free.
   assign b_fire     = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign a_free     = !a_valid_ff || b_fire;
   assign q_pop      = q_status.valid && a_free;
   assign a_valid_in = q_pop || (a_valid_ff && !b_fire);

   // Reciprocal multiply for the quotient estimate.
   assign prod     = ProdW'(q_item.sum) * ProdW'(Recip);
   assign quot_est = prod[RecipShift +: SAMPLE_W];

   // Correct the estimate by one where the remainder reaches the group size.
   assign prod_back = SUM_W'(a_quot_ff) * GroupConst;
   assign remainder = a_item_ff.sum - prod_back;
   assign avg       = (remainder >= GroupConst) ? a_quot_ff + 1'b1 : a_quot_ff;
   assign slot      = classify(avg, cfg);

   // Counters as they stand for this group, cleared when it opens a scan.
   assign scan_live = a_item_ff.start || active_ff;
   assign seen_base = a_item_ff.start ? '0 : seen_ff;
   assign seen_next = (seen_base == '1) ? seen_base : seen_base + 1'b1;

   always_comb begin
      vote_cur = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         votes_base[i] = a_item_ff.start ? '0 : votes_ff[i];
         if (slot == SLOT_W'(i)) begin
            vote_cur = votes_base[i];
         end
      end
   end

   assign vote_next = (vote_cur == '1) ? vote_cur : vote_cur + 1'b1;
   assign hit       = (slot != SLOT_NO_CLASS) && (vote_next >= cfg.threshold);
   assign timeout   = (seen_next >= cfg.max_avg);

   // Vote, count and decide; a decision ends the scan.
   always_comb begin
      active_in     = active_ff;
      seen_in       = seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_button_in = rsp_button_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         votes_in[i] = votes_ff[i];
      end
      if (b_fire && scan_live) begin
         active_in = 1'b1;
         seen_in   = seen_next;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            votes_in[i] = (slot == SLOT_W'(i)) ? vote_next : votes_base[i];
         end
         if (hit) begin
            rsp_valid_in  = 1'b1;
            rsp_button_in = slot_code(slot, cfg.mode);
            active_in     = 1'b0;
         end else if (timeout) begin
            rsp_valid_in  = 1'b1;
            rsp_button_in = BTN_TIMEOUT;
            active_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         active_ff    <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            votes_ff[i] <= '0;
         end
      end else begin
         a_valid_ff   <= a_valid_in;
         active_ff    <= active_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            votes_ff[i] <= votes_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_button_ff <= rsp_button_in;
      if (q_pop) begin
         a_item_ff <= q_item;
         a_quot_ff <= quot_est;
      end
   end

endmodule

/* hdl/resistor_ladder_button_decoder_core.sv */
`timescale 1ns / 1ps

// Resistor-ladder keypad decoder.
// Requests carry one raw ADC sample and a scan_start flag on a valid/ready
// channel; a request with scan_start set opens a new scan with that sample.
// Samples are summed in groups of GROUP_SIZE, each group average is sorted
// into a button window and voted on, and a scan ends with one response on
// the rsp channel: the decided button, or timeout.
// The csr port writes the mode, vote threshold, average limit and null level,
// and is meant to be written only while no request is in flight.
// Throughput: one request per cycle while the queue has room. The accumulator
// ends a group into a four-entry queue; the divide and decision stages take
// one group per cycle while the output is free. A response passes through the
// queue, the divide register and the output register after its closing request.
// If rsp_ready stays low the response is held, the decision stages stop and
// the queue fills; req_ready drops only once the queue is full.
// Reset (synchronous) clears all scan state and loads the default register
// values; no scan is active until a request with scan_start arrives.
module resistor_ladder_button_decoder_core import rlbd_pkg::*; #(
   parameter int GROUP_SIZE = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   req_scan_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BUTTON_W-1:0]    rsp_button,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             q_push, q_pop;
   group_type        q_push_item, q_head_item;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LADDER_MODE:    cfg_in.mode       = csr_wdata[0];
            CSR_VOTE_THRESHOLD: cfg_in.threshold  = csr_wdata[COUNT_W-1:0];
            CSR_MAX_AVERAGES:   cfg_in.max_avg    = csr_wdata[COUNT_W-1:0];
            CSR_NULL_LEVEL:     cfg_in.null_level = csr_wdata[SAMPLE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= RESET_LADDER_MODE;
         cfg_ff.threshold  <= RESET_VOTE_THRESHOLD;
         cfg_ff.max_avg    <= RESET_MAX_AVERAGES;
         cfg_ff.null_level <= RESET_NULL_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sample accumulator.
   rlbd_front #(
      .GROUP_SIZE(GROUP_SIZE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_scan_start (req_scan_start),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_item         (q_push_item)
   );

   // Group queue.
   rlbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .status    (q_status)
   );

   // Divide, classify, vote and respond.
   rlbd_back #(
      .GROUP_SIZE(GROUP_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_item     (q_head_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_button (rsp_button)
   );

   // The accumulator never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("group pushed into a full queue");

   // The decision logic never pops an empty queue.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && !q_status.valid))
      else $error("group popped from an empty queue");

   // A group can only be pushed while the request that closes it is taken.
   a_push_needs_request: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_valid && req_ready))
      else $error("group pushed without an accepted request");

   // No response is pending right after reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

/* tb/sv/tb_resistor_ladder_button_decoder_core.sv */
`timescale 1ns / 1ps

module tb_resistor_ladder_button_decoder_core;
   import rlbd_pkg::*;

   localparam int GROUP         = 5;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PCT      = 17;
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEMS         = 1900;
   localparam int CYCLE_LIMIT   = 400000;

   // Tracks the decoder state and the buttons it must still report.
   class keypad_scoreboard;
      bit                  mode;
      bit [COUNT_W-1:0]    vote_target;
      bit [COUNT_W-1:0]    average_limit;
      bit [SAMPLE_W-1:0]   null_floor;
      bit [SUM_W-1:0]      sample_total;
      bit [FILL_W-1:0]     group_count;
      bit [COUNT_W-1:0]    averages_done;
      bit [COUNT_W-1:0]    votes [NUM_SLOTS];
      bit                  scanning;
      logic [BUTTON_W-1:0] expected_buttons [$];
      int                  buttons_predicted;
      int                  mismatches;

      function new();
         mode          = RESET_LADDER_MODE;
         vote_target   = RESET_VOTE_THRESHOLD;
         average_limit = RESET_MAX_AVERAGES;
         null_floor    = RESET_NULL_LEVEL;
         clear_scan();
         scanning          = 1'b0;
         buttons_predicted = 0;
         mismatches        = 0;
      endfunction

      function void clear_scan();
         sample_total  = '0;
         group_count   = '0;
         averages_done = '0;
         foreach (votes[i]) votes[i] = '0;
      endfunction

      // Only the low bits of a register survive a write.
      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_LADDER_MODE:    mode          = value[0];
            CSR_VOTE_THRESHOLD: vote_target   = value[COUNT_W-1:0];
            CSR_MAX_AVERAGES:   average_limit = value[COUNT_W-1:0];
            CSR_NULL_LEVEL:     null_floor    = value[SAMPLE_W-1:0];
            default: ;
         endcase
      endfunction

      // Windows are tested in order with exclusive bounds, then the null test.
      function bit [SLOT_W-1:0] classify_average(bit [SAMPLE_W-1:0] avg);
         if (!mode) begin
            if (avg > NORTH_LO && avg < NORTH_HI) return SLOT_FIRST;
            if (avg > EAST_LO && avg < EAST_HI) return SLOT_SECOND;
            if (avg > WEST_LO && avg < WEST_HI) return SLOT_THIRD;
            if (avg > SOUTH_LO && avg < SOUTH_HI) return SLOT_FOURTH;
         end else begin
            if (avg > AUX_WEST_LO && avg < AUX_WEST_HI) return SLOT_FIRST;
            if (avg > AUX_EAST_LO && avg < AUX_EAST_HI) return SLOT_SECOND;
         end
         if (avg < null_floor) return SLOT_NONE;
         return SLOT_NO_CLASS;
      endfunction

      // A slot maps onto the window at the same position in the current mode.
      function logic [BUTTON_W-1:0] button_for(bit [SLOT_W-1:0] slot);
         case (slot)
            SLOT_NONE:   return BTN_NONE;
            SLOT_FIRST:  return mode ? BTN_AUX_WEST : BTN_NORTH;
            SLOT_SECOND: return mode ? BTN_AUX_EAST : BTN_EAST;
            SLOT_THIRD:  return mode ? BTN_AUX_WEST : BTN_WEST;
            default:     return mode ? BTN_AUX_EAST : BTN_SOUTH;
         endcase
      endfunction

      function void finish_scan(logic [BUTTON_W-1:0] button);
         expected_buttons.push_back(button);
         buttons_predicted++;
         scanning = 1'b0;
      endfunction

      // Advances the decoder by one accepted request.
      function void note_request(bit [SAMPLE_W-1:0] sample, bit start);
         bit [SAMPLE_W-1:0] avg;
         bit [SLOT_W-1:0]   slot;
         if (start) begin
            clear_scan();
            scanning = 1'b1;
         end
         if (!scanning) return;
         sample_total += SUM_W'(sample);
         group_count  += 1'b1;
         if (group_count != FILL_W'(GROUP)) return;
         avg          = SAMPLE_W'(sample_total / SUM_W'(GROUP));
         sample_total = '0;
         group_count  = '0;
         if (averages_done != '1) averages_done += 1'b1;
         slot = classify_average(avg);
         // The vote test comes before the timeout test.
         if (slot != SLOT_NO_CLASS) begin
            if (votes[slot] != '1) votes[slot] += 1'b1;
            if (votes[slot] >= vote_target) begin
               finish_scan(button_for(slot));
               return;
            end
         end
         if (averages_done >= average_limit) finish_scan(BTN_TIMEOUT);
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $time, msg);
      endfunction

      // Compares one response with the oldest predicted button.
      function void check_button(logic [BUTTON_W-1:0] got);
         logic [BUTTON_W-1:0] want;
         if (expected_buttons.size() == 0) begin
            report_mismatch($sformatf("unexpected button %0d", got));
            return;
         end
         want = expected_buttons.pop_front();
         if (got !== want) report_mismatch($sformatf("button expected %0d, got %0d", want, got));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   req_scan_start;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BUTTON_W-1:0]    rsp_button;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   keypad_scoreboard board;
   bit calm;
   bit noise_on;
   int useful_requests;
   int cycle_count;
   int phase_no;

   resistor_ladder_button_decoder_core #(
      .GROUP_SIZE(GROUP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_scan_start (req_scan_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_button     (rsp_button),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The receiver stalls at random except during the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
   end

   // Every accepted response is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_button(rsp_button);
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_resistor_ladder_button_decoder_core: errors");
         $finish;
      end
   end

   // Drives one request and waits for it to be taken; returns at a falling edge.
   task automatic send_request(input logic [SAMPLE_W-1:0] sample, input logic start);
      while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= sample;
      req_scan_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (start || board.scanning) useful_requests++;
      board.note_request(sample, start);
      @(negedge clock);
   endtask

   // Sends one group of samples whose truncated average is avg.
   task automatic send_group(input int avg, input logic start);
      int remaining;
      int low;
      int high;
      int s;
      int k;
      remaining = GROUP * avg + int'($urandom_range(GROUP - 1, 0));
      if (remaining > GROUP * SAMPLE_MAX) remaining = GROUP * SAMPLE_MAX;
      for (k = 0; k < GROUP; k++) begin
         // A stray request now and then, which may also restart the scan.
         if (noise_on && $urandom_range(99, 0) < 3)
            send_request(SAMPLE_W'($urandom), $urandom_range(3, 0) == 0);
         low  = remaining - SAMPLE_MAX * (GROUP - 1 - k);
         high = (remaining < SAMPLE_MAX) ? remaining : SAMPLE_MAX;
         if (low < 0) low = 0;
         s = (k == GROUP - 1) ? remaining : avg + int'($urandom_range(48, 0)) - 24;
         if (s < low) s = low;
         if (s > high) s = high;
         send_request(SAMPLE_W'(s), start && k == 0);
         remaining -= s;
      end
   endtask

   // Lets all responses arrive, then waits out the decision pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_buttons.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      board.set_register(index, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] mode_word,
                            input logic [CSR_DATA_W-1:0] threshold_word,
                            input logic [CSR_DATA_W-1:0] limit_word,
                            input logic [CSR_DATA_W-1:0] null_word);
      write_register(CSR_LADDER_MODE, mode_word);
      write_register(CSR_VOTE_THRESHOLD, threshold_word);
      write_register(CSR_MAX_AVERAGES, limit_word);
      write_register(CSR_NULL_LEVEL, null_word);
      csr_write_en <= 1'b0;
   endtask

   function automatic int window_edge(bit mode, int k, bit upper);
      if (!mode) begin
         case (k)
            0:       return upper ? NORTH_HI : NORTH_LO;
            1:       return upper ? EAST_HI : EAST_LO;
            2:       return upper ? WEST_HI : WEST_LO;
            default: return upper ? SOUTH_HI : SOUTH_LO;
         endcase
      end
      return (k == 0) ? (upper ? AUX_WEST_HI : AUX_WEST_LO) : (upper ? AUX_EAST_HI : AUX_EAST_LO);
   endfunction

   // The button held down for a scan: a window index, or -1 for none pressed.
   function automatic int pick_favored(bit mode, int null_floor);
      if (null_floor > 0 && $urandom_range(99, 0) < 15) return -1;
      return $urandom_range(mode ? 1 : 3, 0);
   endfunction

   // Mostly the held button, otherwise window edges, the null level and noise.
   function automatic int pick_average(bit mode, int favored, int null_floor);
      int r;
      int k;
      int lo;
      int hi;
      r = $urandom_range(99, 0);
      if (r < 65 && favored >= 0)
         return $urandom_range(window_edge(mode, favored, 1) - 1, window_edge(mode, favored, 0) + 1);
      if (r < 65 && null_floor > 0) return $urandom_range(null_floor - 1, 0);
      if (r < 80) begin
         k  = $urandom_range(mode ? 1 : 3, 0);
         lo = window_edge(mode, k, 0);
         hi = window_edge(mode, k, 1);
         case ($urandom_range(3, 0))
            0:       return lo;
            1:       return lo + 1;
            2:       return hi - 1;
            default: return hi;
         endcase
      end
      if (r < 90 || null_floor == 0) return $urandom_range(SAMPLE_MAX, 0);
      return $urandom_range(null_floor, null_floor - 1);
   endfunction

   // One random setting followed by a run of scans; may stop mid-scan.
   task automatic run_phase(input int index);
      bit mode;
      int r;
      int threshold;
      int limit;
      int null_floor;
      int favored;
      calm = (index >= 3 && index <= 5);
      mode = 1'($urandom_range(1, 0));
      r = $urandom_range(99, 0);
      threshold = (r < 10) ? 0 : (r < 20) ? 255 : (r < 25) ? 1 : $urandom_range(6, 1);
      r = $urandom_range(99, 0);
      limit = (r < 10) ? 0 : (r < 20) ? 255 : (r < 30) ? 1 : $urandom_range(30, 3);
      // Keep scans short when one extreme would make them run long.
      if (threshold == 255) limit = $urandom_range(8, 1);
      if (limit == 255 && threshold > 3) threshold = $urandom_range(3, 1);
      r = $urandom_range(99, 0);
      null_floor = (r < 10) ? 0 : (r < 20) ? SAMPLE_MAX : $urandom_range(400, 1);
      configure({9'($urandom), mode}, {2'($urandom), 8'(threshold)},
                {2'($urandom), 8'(limit)}, CSR_DATA_W'(null_floor));
      favored = pick_favored(mode, null_floor);
      repeat ($urandom_range(30, 8)) begin
         if (!board.scanning) begin
            if ($urandom_range(99, 0) < 20) send_request(SAMPLE_W'($urandom), 1'b0);
            favored = pick_favored(mode, null_floor);
            send_group(pick_average(mode, favored, null_floor), 1'b1);
         end else begin
            send_group(pick_average(mode, favored, null_floor), 1'b0);
         end
      end
      drain();
   endtask

   initial begin
      board           = new();
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_scan_start  = 1'b0;
      rsp_ready       = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      calm            = 1'b0;
      noise_on        = 1'b0;
      useful_requests = 0;
      cycle_count     = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Samples arriving with no scan open are dropped.
      send_request('0, 1'b0);
      send_request(SAMPLE_W'(SAMPLE_MAX), 1'b0);
      drain();

      // Zero threshold with wide register words: the first classified average decides.
      configure(10'h3FE, 10'h300, 10'h201, 10'd5);
      send_group(869, 1'b1);
      send_group(SAMPLE_MAX, 1'b1);
      send_group(0, 1'b1);
      drain();

      // Zero average limit: timeout right after the first undecided average.
      configure(10'd0, 10'd2, 10'd0, 10'd5);
      send_group(313, 1'b1);
      drain();

      // A vote for the second slot carries over when the mode changes mid-scan.
      configure(10'd0, 10'd2, 10'd5, 10'd5);
      send_group(720, 1'b1);
      drain();
      write_register(CSR_LADDER_MODE, 10'd1);
      csr_write_en <= 1'b0;
      send_group(310, 1'b0);
      drain();

      // Random scans under changing settings.
      noise_on = 1'b1;
      phase_no = 0;
      while (useful_requests < ITEMS) begin
         run_phase(phase_no);
         phase_no++;
      end
      calm = 1'b0;
      drain();

      if (board.expected_buttons.size() != 0)
         board.report_mismatch($sformatf("%0d buttons never reported",
                                         board.expected_buttons.size()));
      if (board.mismatches == 0) begin
         $display("tb_resistor_ladder_button_decoder_core: clean");
      end else begin
         $display("tb_resistor_ladder_button_decoder_core: errors");
      end
      $finish;
   end

endmodule
